@@ src/pqa_pkg.sv @@
// Package for the aging priority queue: beat structs, status codes and the control record.
// Used by every module of the block; depends on nothing.
package pqa_pkg;

    localparam int ID_W   = 16;
    localparam int PRIO_W = 8;
    localparam int OCC_W  = 5;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_BAD   = 2'd3
    } status_t;

    localparam logic OP_INSERT   = 1'b0;
    localparam logic OP_RETRIEVE = 1'b1;

    typedef struct packed {
        logic              operation;
        logic [ID_W-1:0]   item_id;
        logic [PRIO_W-1:0] item_priority;
    } req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [ID_W-1:0]   taken_id;
        logic [OCC_W-1:0]  occupancy;
    } rsp_t;

    // Command from the controller to the cell chain.
    typedef struct packed {
        logic do_insert;
        logic do_retrieve;
    } cmd_t;

    // Status from the cell chain to the controller.
    typedef struct packed {
        logic is_full;
        logic is_empty;
    } stat_t;

endpackage

@@ src/pqa_ctrl.sv @@
// Controller of the aging priority queue: checks each request and issues the command.
// Depends on pqa_pkg.
module pqa_ctrl #(
    parameter int PRIORITY_MAX = 255,
    parameter int ID_MAX       = 65535
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  pqa_pkg::req_t  req,
    input  pqa_pkg::stat_t stat,
    output pqa_pkg::cmd_t  cmd,
    output logic           busy,
    output logic           result_valid,
    output logic [1:0]     status
);
    import pqa_pkg::*;

    typedef enum logic {S_IDLE} state_t;

    state_t     state_reg;
    logic       valid_reg;
    logic [1:0] status_reg;
    logic       bad_arg;
    logic [1:0] status_next;

    // Argument check comes before the fullness check.
    always_comb
    begin
        bad_arg = (req.item_priority == '0)
               || ({24'd0, req.item_priority} > 32'(PRIORITY_MAX))
               || ({16'd0, req.item_id} > 32'(ID_MAX));
        cmd = '0;
        status_next = ST_DONE;
        if (req.operation == OP_INSERT)
        begin
            if (bad_arg)
                status_next = ST_BAD;
            else if (stat.is_full)
                status_next = ST_FULL;
            else
                cmd.do_insert = start;
        end
        else
        begin
            if (stat.is_empty)
                status_next = ST_EMPTY;
            else
                cmd.do_retrieve = start;
        end
    end

    // Each request's result is registered in the idle state, so the machine stays in its single state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            valid_reg  <= 1'b0;
            status_reg <= ST_DONE;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    valid_reg <= start;
                    if (start)
                        status_reg <= status_next;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy         = 1'b0;
    assign result_valid = valid_reg;
    assign status       = status_reg;

endmodule

@@ src/pqa_cells.sv @@
// Datapath of the aging priority queue: a chain of sorted cells that shift and age in parallel.
// Depends on pqa_pkg.
module pqa_cells #(
    parameter int DEPTH = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  pqa_pkg::cmd_t           cmd,
    input  logic [pqa_pkg::ID_W-1:0]   new_id,
    input  logic [pqa_pkg::PRIO_W-1:0] new_prio,
    output pqa_pkg::stat_t          stat,
    output logic [pqa_pkg::ID_W-1:0]   head_id,
    output logic [pqa_pkg::OCC_W-1:0]  occupancy
);
    import pqa_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    logic [ID_W-1:0]   id_reg   [DEPTH];
    logic [PRIO_W-1:0] prio_reg [DEPTH];
    logic [CW-1:0]     count_reg;
    logic [DEPTH-1:0]  occ;
    logic [DEPTH-1:0]  after;
    logic [ID_W-1:0]   head_reg;

    // Each cell decides locally: occupied and its priority above the new one.
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            occ[i]   = (CW'(i) < count_reg);
            after[i] = occ[i] && (prio_reg[i] > new_prio);
        end
    end

    // Cell update: shift down on insert, shift up and age on retrieve.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            if (cmd.do_insert)
            begin
                if (after[i])
                begin
                    if (i > 0 && after[(i > 0) ? i - 1 : 0])
                    begin
                        id_reg[i]   <= id_reg[(i > 0) ? i - 1 : 0];
                        prio_reg[i] <= prio_reg[(i > 0) ? i - 1 : 0];
                    end
                    else
                    begin
                        id_reg[i]   <= new_id;
                        prio_reg[i] <= new_prio;
                    end
                end
                else if (!occ[i] && (i == 0 || occ[(i > 0) ? i - 1 : 0]))
                begin
                    if (i > 0 && after[(i > 0) ? i - 1 : 0])
                    begin
                        id_reg[i]   <= id_reg[(i > 0) ? i - 1 : 0];
                        prio_reg[i] <= prio_reg[(i > 0) ? i - 1 : 0];
                    end
                    else
                    begin
                        id_reg[i]   <= new_id;
                        prio_reg[i] <= new_prio;
                    end
                end
            end
            else if (cmd.do_retrieve && i < DEPTH - 1)
            begin
                id_reg[i] <= id_reg[(i < DEPTH - 1) ? i + 1 : i];
                prio_reg[i] <= (prio_reg[(i < DEPTH - 1) ? i + 1 : i] > PRIO_W'(1))
                             ? prio_reg[(i < DEPTH - 1) ? i + 1 : i] - PRIO_W'(1)
                             : prio_reg[(i < DEPTH - 1) ? i + 1 : i];
            end
        end
    end

    // Head id is captured with the retrieve so it lines up with the result beat.
    always_ff @(posedge clk)
    begin
        head_reg <= cmd.do_retrieve ? id_reg[0] : '0;
    end

    // Fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (cmd.do_insert)
            count_reg <= count_reg + CW'(1);
        else if (cmd.do_retrieve)
            count_reg <= count_reg - CW'(1);
    end

    assign stat.is_full  = (count_reg == CW'(DEPTH));
    assign stat.is_empty = (count_reg == '0);
    assign head_id       = head_reg;
    assign occupancy     = OCC_W'(count_reg);

endmodule

@@ src/priority_queue_with_aging.sv @@
// Top level of the aging priority queue: joins the controller and the cell chain.
// Depends on pqa_pkg, pqa_ctrl and pqa_cells.
//
// Every request beat is taken in any cycle (busy is always low) and its result beat
// appears on the next cycle, marked by done, for exactly one cycle: one item per clock,
// set by the chain of cells that shifts and ages all entries in the same cycle.
// The receiver cannot hold a result beat off, so it must take each one as it appears.
// A rejected request leaves the queue unchanged and reports its status.
module priority_queue_with_aging #(
    parameter int DEPTH        = 16,
    parameter int PRIORITY_MAX = 255,
    parameter int ID_MAX       = 65535
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  pqa_pkg::req_t req,
    output logic          done,
    output pqa_pkg::rsp_t rsp
);
    import pqa_pkg::*;

    cmd_t             cmd;
    stat_t            stat;
    logic [1:0]       status;
    logic [ID_W-1:0]  head_id;
    logic [OCC_W-1:0] occupancy;

    pqa_ctrl #(
        .PRIORITY_MAX(PRIORITY_MAX),
        .ID_MAX(ID_MAX)
    ) u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .req(req),
        .stat(stat),
        .cmd(cmd),
        .busy(busy),
        .result_valid(done),
        .status(status)
    );

    pqa_cells #(
        .DEPTH(DEPTH)
    ) u_cells (
        .clk(clk),
        .rst_n(rst_n),
        .cmd(cmd),
        .new_id(req.item_id),
        .new_prio(req.item_priority),
        .stat(stat),
        .head_id(head_id),
        .occupancy(occupancy)
    );

    // Result beat.
    always_comb
    begin
        rsp.status    = status;
        rsp.taken_id  = head_id;
        rsp.occupancy = occupancy;
    end

    // Insert and retrieve are never issued together.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.do_insert && cmd.do_retrieve))
        else $error("insert and retrieve issued together");

    // A successful insert is never made into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.do_insert |-> !stat.is_full)
        else $error("insert into full queue");

    // A rejected beat reports no taken id.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.status != ST_DONE) |-> rsp.taken_id == '0)
        else $error("rejected beat carries an id");

endmodule
